// ----- src/sle_pkg.sv -----
// Shared constants, request codes and result type for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int REQ_W    = 3;
  localparam int DATA_W   = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [REQ_W-1:0] REQ_INS_END   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_END   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_POS   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              empty;
  } res_t;

endpackage

// ----- src/sle_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sle_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sle_seq.sv -----
// Request sequencer: checks, shifts, reads and searches the list through the RAM.
`timescale 1ns / 1ps

module sle_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [sle_pkg::REQ_W-1:0]   req_type_i,
  input  logic [sle_pkg::CNT_W-1:0]   position_i,
  input  logic [sle_pkg::DATA_W-1:0]  record_value_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output sle_pkg::res_t               res_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SHUP = 3'd1;
  localparam logic [2:0] ST_SHDN = 3'd2;
  localparam logic [2:0] ST_RDW  = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int AW = sle_pkg::ADDR_W;
  localparam int CW = sle_pkg::CNT_W;
  localparam int DW = sle_pkg::DATA_W;
  localparam logic [CW-1:0] CAP = CW'(sle_pkg::CAPACITY);

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [DW-1:0] val_q, val_d;
  logic          rdv_q, rdv_d;
  logic [AW-1:0] radr_q, radr_d;
  logic          ok_q, ok_d;
  logic [DW-1:0] data_q, data_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [CW-1:0] ipos, rpos;
  logic          hit;

  sle_ram #(
    .DW   (DW),
    .DEPTH(sle_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign req_ready_o = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_DONE);
  assign hit         = rdv_q && (rdata == val_q);

  always_comb begin
    case (req_type_i)
      sle_pkg::REQ_INS_END:   ipos = cnt_q;
      sle_pkg::REQ_INS_FRONT: ipos = '0;
      default:                ipos = position_i;
    endcase
    case (req_type_i)
      sle_pkg::REQ_REM_END:   rpos = cnt_q - CW'(1);
      sle_pkg::REQ_REM_FRONT: rpos = '0;
      default:                rpos = position_i;
    endcase
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    val_d  = val_q;
    rdv_d  = rdv_q;
    radr_d = radr_q;
    ok_d   = ok_q;
    data_d = data_q;
    we     = 1'b0;
    waddr  = radr_q;
    wdata  = rdata;
    re     = 1'b0;
    raddr  = radr_q;
    case (st_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          ok_d   = 1'b0;
          data_d = '0;
          rdv_d  = 1'b0;
          val_d  = record_value_i;
          st_d   = ST_DONE;
          case (req_type_i)
            sle_pkg::REQ_INS_END, sle_pkg::REQ_INS_FRONT, sle_pkg::REQ_INS_POS: begin
              if ((cnt_q < CAP) && (ipos <= cnt_q)) begin
                idx_d = cnt_q;
                pos_d = ipos;
                st_d  = ST_SHUP;
              end
            end
            sle_pkg::REQ_REM_END, sle_pkg::REQ_REM_FRONT, sle_pkg::REQ_REM_POS: begin
              if ((cnt_q != '0) && (rpos < cnt_q)) begin
                idx_d = rpos + CW'(1);
                st_d  = ST_SHDN;
              end
            end
            sle_pkg::REQ_READ: begin
              if ((position_i != '0) && (position_i <= cnt_q)) begin
                re    = 1'b1;
                raddr = AW'(position_i - CW'(1));
                st_d  = ST_RDW;
              end
            end
            default: begin
              idx_d = '0;
              st_d  = ST_SRCH;
            end
          endcase
        end
      end
      ST_SHUP: begin
        we    = rdv_q;
        waddr = radr_q + AW'(1);
        if (idx_q > pos_q) begin
          re     = 1'b1;
          raddr  = AW'(idx_q - CW'(1));
          radr_d = raddr;
          idx_d  = idx_q - CW'(1);
          rdv_d  = 1'b1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            we    = 1'b1;
            waddr = AW'(pos_q);
            wdata = val_q;
            cnt_d = cnt_q + CW'(1);
            ok_d  = 1'b1;
            st_d  = ST_DONE;
          end
        end
      end
      ST_SHDN: begin
        we    = rdv_q;
        waddr = radr_q - AW'(1);
        if (idx_q < cnt_q) begin
          re     = 1'b1;
          raddr  = AW'(idx_q);
          radr_d = raddr;
          idx_d  = idx_q + CW'(1);
          rdv_d  = 1'b1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            cnt_d = cnt_q - CW'(1);
            ok_d  = 1'b1;
            st_d  = ST_DONE;
          end
        end
      end
      ST_RDW: begin
        data_d = rdata;
        ok_d   = 1'b1;
        st_d   = ST_DONE;
      end
      ST_SRCH: begin
        if (hit) begin
          rdv_d = 1'b0;
          ok_d  = 1'b1;
          st_d  = ST_DONE;
        end else if (idx_q < cnt_q) begin
          re     = 1'b1;
          raddr  = AW'(idx_q);
          radr_d = raddr;
          idx_d  = idx_q + CW'(1);
          rdv_d  = 1'b1;
        end else if (!rdv_q) begin
          st_d = ST_DONE;
        end else begin
          rdv_d = 1'b0;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      rdv_q <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    radr_q <= radr_d;
    ok_q   <= ok_d;
    data_q <= data_d;
  end

  assign res_o.ok    = ok_q;
  assign res_o.data  = data_q;
  assign res_o.count = cnt_q;
  assign res_o.full  = (cnt_q == CAP);
  assign res_o.empty = (cnt_q == '0);

endmodule

// ----- src/sequential_list_engine_core.sv -----
// Top level of the sequential list engine: stream ports, sequencer and output register.
//
//   channel  direction  tdata (low bit up)                       tuser
//   s_axis   in         position[6:0], record_value[38:7]       req_type[2:0]
//   m_axis   out        ok[0], read_data[32:1], entry_count[39:33],
//                       is_full[40], is_empty[41]                -
//
// Insert walks one slot per cycle, shifting entries above the position up; none move at the end.
// Remove shifts the entries above the position down (none for the last); search stops at a hit.
// Read uses the single RAM read port; a failed request returns ok low with zero data.
// Reset empties the list at once; the RAM contents are not cleared.
// The output register frees the sequencer; a stalled result holds the next one in the sequencer.
`timescale 1ns / 1ps

module sequential_list_engine_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sle_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // position, record_value
  input  logic [sle_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sle_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // ok, read_data, entry_count,
                                                             // is_full, is_empty
);

  localparam int CW = sle_pkg::CNT_W;
  localparam int DW = sle_pkg::DATA_W;

  logic          res_valid, res_ready;
  sle_pkg::res_t res;
  sle_pkg::res_t out_q;
  logic          out_v_q;

  sle_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_type_i    (s_axis_tuser),
    .position_i    (s_axis_tdata[CW-1:0]),
    .record_value_i(s_axis_tdata[CW+DW-1:CW]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  assign res_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_q.empty, out_q.full, out_q.count, out_q.data, out_q.ok};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer took a second item while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.count <= CW'(sle_pkg::CAPACITY)))
    else $error("entry count above capacity");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_q.full && out_q.empty))
    else $error("list reported both full and empty");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.ok) |-> (out_q.data == '0))
    else $error("failed request returned nonzero data");

endmodule
